FILE: sv/rfps_pkg.sv
package rfps_pkg;

  // field widths
  localparam int unsigned CoordBits  = 12;
  localparam int unsigned CovBits    = 8;
  localparam int unsigned DimBits    = 13;
  localparam int unsigned RadiusBits = 8;
  localparam int unsigned BandBits   = 8;
  localparam int unsigned TitleBits  = 10;
  localparam int unsigned ColorBits  = 32;
  localparam int unsigned ChanBits   = 8;

  // signed working width for position compares
  localparam int unsigned PosBits = ((CoordBits > DimBits) ? CoordBits : DimBits) + 2;

  // squared distance and square root sizing
  localparam int unsigned SqBits         = 2 * RadiusBits;
  localparam int unsigned SumBits        = SqBits + 1;
  localparam int unsigned SqrtShift      = 2 * CovBits + 2;
  localparam int unsigned RootBits       = (SumBits + SqrtShift + 1) / 2;
  localparam int unsigned RadBits        = 2 * RootBits;
  localparam int unsigned RemBits        = RootBits + 3;
  localparam int unsigned StepsPerStage  = 2;
  localparam int unsigned SqrtStages     = (RootBits + StepsPerStage - 1) / StepsPerStage;

  // coverage holds 0 .. 2^CovBits
  localparam int unsigned CovW = CovBits + 1;

  // reset values of the registers
  localparam logic [DimBits-1:0]    FrameWidthRst  = DimBits'(640);
  localparam logic [DimBits-1:0]    FrameHeightRst = DimBits'(480);
  localparam logic [RadiusBits-1:0] RadiusRst      = '0;
  localparam logic [BandBits-1:0]   BorderRst      = BandBits'(1);
  localparam logic [TitleBits-1:0]  TitleRst       = TitleBits'(24);
  localparam logic [ColorBits-1:0]  BorderColorRst = 32'hFF00_0000;
  localparam logic [ColorBits-1:0]  TitleColorRst  = 32'hFF80_8080;
  localparam logic [ColorBits-1:0]  BodyColorRst   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    COV_FULL = 2'd0,
    COV_ZERO = 2'd1,
    COV_PART = 2'd2
  } cov_cls_e;

  typedef struct packed {
    logic [DimBits-1:0]    frame_width;
    logic [DimBits-1:0]    frame_height;
    logic [RadiusBits-1:0] corner_radius;
    logic [BandBits-1:0]   border_width;
    logic [TitleBits-1:0]  title_height;
    logic [ColorBits-1:0]  border_color;
    logic [ColorBits-1:0]  title_color;
    logic [ColorBits-1:0]  body_color;
  } cfg_t;

  // travels alongside the root through the sqrt pipe
  typedef struct packed {
    logic [ColorBits-1:0]  color;
    logic [RadiusBits-1:0] radius;
    cov_cls_e              cls;
  } side_t;

endpackage

FILE: sv/rfps_geom.sv
module rfps_geom (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [rfps_pkg::CoordBits-1:0]      x_i,
  input  logic [rfps_pkg::CoordBits-1:0]      y_i,
  input  rfps_pkg::cfg_t                      cfg_i,
  output logic                                valid_o,
  output logic [rfps_pkg::RadBits-1:0]        rad_o,
  output rfps_pkg::side_t                     side_o
);

  localparam int unsigned Pb = rfps_pkg::PosBits;
  localparam int unsigned Rb = rfps_pkg::RadiusBits;

  // ---------------- stage a: offsets and color choice
  logic signed [Pb-1:0] xs, ys, ws, hs, rs, bws;
  logic signed [Pb-1:0] x_right, y_bottom, x_band, y_band;
  logic                 border, title;

  logic                           a_vld_q;
  logic                           a_xlt_d, a_xlt_q, a_ylt_d, a_ylt_q;
  logic [Rb-1:0]                  a_dxlo_d, a_dxlo_q, a_dylo_d, a_dylo_q;
  logic signed [Pb-1:0]           a_dxhi_q, a_dyhi_q;
  logic [rfps_pkg::ColorBits-1:0] a_color_d, a_color_q;
  logic [Rb-1:0]                  a_r_q;

  assign xs  = $signed(Pb'(x_i));
  assign ys  = $signed(Pb'(y_i));
  assign ws  = $signed(Pb'(cfg_i.frame_width));
  assign hs  = $signed(Pb'(cfg_i.frame_height));
  assign rs  = $signed(Pb'(cfg_i.corner_radius));
  assign bws = $signed(Pb'(cfg_i.border_width));

  assign x_right  = xs - ws + rs;
  assign y_bottom = ys - hs + rs;
  assign x_band   = xs - ws + bws;
  assign y_band   = ys - hs + bws;

  assign a_xlt_d  = Pb'(x_i) < Pb'(cfg_i.corner_radius);
  assign a_ylt_d  = Pb'(y_i) < Pb'(cfg_i.corner_radius);
  // only used when the coordinate is below the radius, so it fits
  assign a_dxlo_d = Rb'(cfg_i.corner_radius - Rb'(1) - x_i[Rb-1:0]);
  assign a_dylo_d = Rb'(cfg_i.corner_radius - Rb'(1) - y_i[Rb-1:0]);

  assign border = (Pb'(x_i) < Pb'(cfg_i.border_width)) || !x_band[Pb-1] || !y_band[Pb-1];
  assign title  = Pb'(y_i) < Pb'(cfg_i.title_height);

  always_comb begin
    if (border) begin
      a_color_d = cfg_i.border_color;
    end else if (title) begin
      a_color_d = cfg_i.title_color;
    end else begin
      a_color_d = cfg_i.body_color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_xlt_q   <= a_xlt_d;
      a_ylt_q   <= a_ylt_d;
      a_dxlo_q  <= a_dxlo_d;
      a_dylo_q  <= a_dylo_d;
      a_dxhi_q  <= x_right;
      a_dyhi_q  <= y_bottom;
      a_color_q <= a_color_d;
      a_r_q     <= cfg_i.corner_radius;
    end
  end

  // ---------------- stage b: pick offset, flag corner and far cases
  logic [Pb-1:0] dx, dy;

  function automatic logic [Pb-1:0] pick_offset(input logic lt, input logic [Rb-1:0] lo,
                                                input logic signed [Pb-1:0] hi);
    logic [Pb-1:0] res;
    if (lt) begin
      res = Pb'(lo);
    end else if (hi[Pb-1]) begin
      res = '0;
    end else begin
      res = hi;
    end
    return res;
  endfunction

  assign dx = pick_offset(a_xlt_q, a_dxlo_q, a_dxhi_q);
  assign dy = pick_offset(a_ylt_q, a_dylo_q, a_dyhi_q);

  logic                           b_vld_q;
  logic                           b_corner_d, b_corner_q, b_far_d, b_far_q;
  logic [Rb-1:0]                  b_dx_q, b_dy_q, b_r_q;
  logic [rfps_pkg::ColorBits-1:0] b_color_q;

  assign b_corner_d = (dx != '0) && (dy != '0);
  // an offset past the radius puts the pixel outside the arc
  assign b_far_d    = (dx > Pb'(a_r_q)) || (dy > Pb'(a_r_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_corner_q <= b_corner_d;
      b_far_q    <= b_far_d;
      b_dx_q     <= dx[Rb-1:0];
      b_dy_q     <= dy[Rb-1:0];
      b_r_q      <= a_r_q;
      b_color_q  <= a_color_q;
    end
  end

  // ---------------- stage c: squares
  localparam int unsigned Sq = rfps_pkg::SqBits;

  logic                           c_vld_q;
  logic [Sq-1:0]                  c_dxx_d, c_dxx_q, c_dyy_d, c_dyy_q;
  logic [Sq-1:0]                  c_rr_d, c_rr_q, c_inner_d, c_inner_q;
  logic [Rb-1:0]                  r_m1;
  logic                           c_corner_q, c_far_q;
  logic [Rb-1:0]                  c_r_q;
  logic [rfps_pkg::ColorBits-1:0] c_color_q;

  assign r_m1      = b_r_q - Rb'(1);
  assign c_dxx_d   = Sq'(b_dx_q) * Sq'(b_dx_q);
  assign c_dyy_d   = Sq'(b_dy_q) * Sq'(b_dy_q);
  assign c_rr_d    = Sq'(b_r_q) * Sq'(b_r_q);
  assign c_inner_d = Sq'(r_m1) * Sq'(r_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_dxx_q    <= c_dxx_d;
      c_dyy_q    <= c_dyy_d;
      c_rr_q     <= c_rr_d;
      c_inner_q  <= c_inner_d;
      c_corner_q <= b_corner_q;
      c_far_q    <= b_far_q;
      c_r_q      <= b_r_q;
      c_color_q  <= b_color_q;
    end
  end

  // ---------------- stage d: classify coverage, form radicand
  logic [rfps_pkg::SumBits-1:0] s_sum;
  rfps_pkg::cov_cls_e           d_cls_d;
  logic                         d_vld_q;
  logic [rfps_pkg::RadBits-1:0] d_rad_d, d_rad_q;
  rfps_pkg::side_t              d_side_q;

  assign s_sum = rfps_pkg::SumBits'(c_dxx_q) + rfps_pkg::SumBits'(c_dyy_q);

  always_comb begin
    if (!c_corner_q) begin
      d_cls_d = rfps_pkg::COV_FULL;
    end else if (c_far_q || (s_sum > rfps_pkg::SumBits'(c_rr_q))) begin
      d_cls_d = rfps_pkg::COV_ZERO;
    end else if (s_sum <= rfps_pkg::SumBits'(c_inner_q)) begin
      d_cls_d = rfps_pkg::COV_FULL;
    end else begin
      d_cls_d = rfps_pkg::COV_PART;
    end
  end

  assign d_rad_d = rfps_pkg::RadBits'(s_sum) << rfps_pkg::SqrtShift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en_i) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_rad_q         <= d_rad_d;
      d_side_q.color  <= c_color_q;
      d_side_q.radius <= c_r_q;
      d_side_q.cls    <= d_cls_d;
    end
  end

  assign valid_o = d_vld_q;
  assign rad_o   = d_rad_q;
  assign side_o  = d_side_q;

endmodule

FILE: sv/rfps_sqrt.sv
module rfps_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [rfps_pkg::RadBits-1:0]  rad_i,
  input  rfps_pkg::side_t               side_i,
  output logic                          valid_o,
  output logic [rfps_pkg::RootBits-1:0] root_o,
  output rfps_pkg::side_t               side_o
);

  localparam int unsigned Ns   = rfps_pkg::SqrtStages;
  localparam int unsigned Nk   = rfps_pkg::StepsPerStage;
  localparam int unsigned RtB  = rfps_pkg::RootBits;
  localparam int unsigned RmB  = rfps_pkg::RemBits;
  localparam int unsigned RdB  = rfps_pkg::RadBits;

  logic [Ns-1:0]   vld_d, vld_q;
  logic [RmB-1:0]  rem_d [Ns];
  logic [RmB-1:0]  rem_q [Ns];
  logic [RtB-1:0]  root_d [Ns];
  logic [RtB-1:0]  root_q [Ns];
  logic [RdB-1:0]  rad_d [Ns];
  logic [RdB-1:0]  rad_q [Ns];
  rfps_pkg::side_t side_d [Ns];
  rfps_pkg::side_t side_q [Ns];

  // restoring digit recurrence, two bits of radicand per step
  always_comb begin
    logic [RmB-1:0] rem;
    logic [RtB-1:0] root;
    logic [RdB-1:0] rad;
    logic [RmB-1:0] trial;
    for (int s = 0; s < Ns; s++) begin
      if (s == 0) begin
        vld_d[s]  = valid_i;
        side_d[s] = side_i;
        rem       = '0;
        root      = '0;
        rad       = rad_i;
      end else begin
        vld_d[s]  = vld_q[s-1];
        side_d[s] = side_q[s-1];
        rem       = rem_q[s-1];
        root      = root_q[s-1];
        rad       = rad_q[s-1];
      end
      for (int k = 0; k < Nk; k++) begin
        if (s * Nk + k < RtB) begin
          rem   = {rem[RmB-3:0], rad[RdB-1 -: 2]};
          rad   = rad << 2;
          trial = RmB'({root, 2'b01});
          if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[RtB-2:0], 1'b1};
          end else begin
            root = {root[RtB-2:0], 1'b0};
          end
        end
      end
      rem_d[s]  = rem;
      root_d[s] = root;
      rad_d[s]  = rad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  assign valid_o = vld_q[Ns-1];
  assign root_o  = root_q[Ns-1];
  assign side_o  = side_q[Ns-1];

endmodule

FILE: sv/rfps_blend.sv
module rfps_blend (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [rfps_pkg::RootBits-1:0]  root_i,
  input  rfps_pkg::side_t                side_i,
  output logic                           valid_o,
  output logic [rfps_pkg::ColorBits-1:0] argb_o
);

  localparam int unsigned F   = rfps_pkg::CovBits;
  localparam int unsigned Cw  = rfps_pkg::CovW;
  localparam int unsigned Wd  = rfps_pkg::RootBits + 1;
  localparam int unsigned Cb  = rfps_pkg::ChanBits;
  localparam int unsigned Pw  = Cb + Cw;
  localparam int unsigned Nch = rfps_pkg::ColorBits / Cb;

  // ---------------- stage e: coverage value
  logic [Wd-1:0]                  rt, top, diff;
  logic [Cw-1:0]                  e_cov_d, e_cov_q;
  logic                           e_vld_q;
  logic [rfps_pkg::ColorBits-1:0] e_color_q;

  // round to nearest from a root with one extra fraction bit
  assign rt   = (Wd'(root_i) + Wd'(1)) >> 1;
  assign top  = Wd'({side_i.radius, F'(0)});
  assign diff = top - rt;

  always_comb begin
    case (side_i.cls)
      rfps_pkg::COV_ZERO: e_cov_d = '0;
      rfps_pkg::COV_PART: e_cov_d = diff[Cw-1:0];
      default:            e_cov_d = Cw'(1) << F;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en_i) begin
      e_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_cov_q   <= e_cov_d;
      e_color_q <= side_i.color;
    end
  end

  // ---------------- stage f: scale each channel, output register
  logic [rfps_pkg::ColorBits-1:0] argb_d, argb_q;
  logic                           out_vld_q;

  always_comb begin
    logic [Pw-1:0] prod;
    for (int c = 0; c < Nch; c++) begin
      prod = Pw'(e_color_q[c*Cb +: Cb]) * Pw'(e_cov_q) + (Pw'(1) << (F - 1));
      argb_d[c*Cb +: Cb] = prod[F +: Cb];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      argb_q <= argb_d;
    end
  end

  assign valid_o = out_vld_q;
  assign argb_o  = argb_q;

endmodule

FILE: sv/rounded_frame_pixel_shader.sv
// the pipe holds 4 geometry stages, 9 square root stages at two root bits each,
//   a coverage stage and the output register
// throughput: one pixel per cycle; the whole pipe advances together and holds
//   while the output transfer is stalled
// reset: rst_ni asynchronous active low, clears all valid bits and loads the
//   register defaults; no clearing pass, ready for pixels right after reset
module rounded_frame_pixel_shader (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // pixel input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rfps_pkg::CoordBits-1:0]     pixel_x_i,
  input  logic [rfps_pkg::CoordBits-1:0]     pixel_y_i,
  // pixel output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rfps_pkg::ColorBits-1:0]     pixel_argb_o,
  // register write port
  input  logic                               cfg_we_i,
  input  logic [3:0]                         cfg_index_i,
  input  logic [rfps_pkg::ColorBits-1:0]     cfg_data_i
);

  // register indexes
  typedef enum logic [3:0] {
    REG_FRAME_WIDTH  = 4'd0,
    REG_FRAME_HEIGHT = 4'd1,
    REG_RADIUS       = 4'd2,
    REG_BORDER_WIDTH = 4'd3,
    REG_TITLE_HEIGHT = 4'd4,
    REG_BORDER_COLOR = 4'd5,
    REG_TITLE_COLOR  = 4'd6,
    REG_BODY_COLOR   = 4'd7
  } reg_idx_e;

  // ---------------- configuration registers
  rfps_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  cfg_d.frame_width   = cfg_data_i[rfps_pkg::DimBits-1:0];
        REG_FRAME_HEIGHT: cfg_d.frame_height  = cfg_data_i[rfps_pkg::DimBits-1:0];
        REG_RADIUS:       cfg_d.corner_radius = cfg_data_i[rfps_pkg::RadiusBits-1:0];
        REG_BORDER_WIDTH: cfg_d.border_width  = cfg_data_i[rfps_pkg::BandBits-1:0];
        REG_TITLE_HEIGHT: cfg_d.title_height  = cfg_data_i[rfps_pkg::TitleBits-1:0];
        REG_BORDER_COLOR: cfg_d.border_color  = cfg_data_i;
        REG_TITLE_COLOR:  cfg_d.title_color   = cfg_data_i;
        REG_BODY_COLOR:   cfg_d.body_color    = cfg_data_i;
        default:          cfg_d = cfg_q; // writes past the list are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= rfps_pkg::FrameWidthRst;
      cfg_q.frame_height  <= rfps_pkg::FrameHeightRst;
      cfg_q.corner_radius <= rfps_pkg::RadiusRst;
      cfg_q.border_width  <= rfps_pkg::BorderRst;
      cfg_q.title_height  <= rfps_pkg::TitleRst;
      cfg_q.border_color  <= rfps_pkg::BorderColorRst;
      cfg_q.title_color   <= rfps_pkg::TitleColorRst;
      cfg_q.body_color    <= rfps_pkg::BodyColorRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------- pipeline advance
  // every stage moves when the output register is empty or its transfer
  // completes, so a stall freezes the whole pipe without loss
  logic pipe_en;

  assign pipe_en    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !pipe_en;

  // ---------------- geometry: corner offsets, color, squares, class
  logic                         geo_valid;
  logic [rfps_pkg::RadBits-1:0] geo_rad;
  rfps_pkg::side_t              geo_side;

  rfps_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_valid_i),
    .x_i     (pixel_x_i),
    .y_i     (pixel_y_i),
    .cfg_i   (cfg_q),
    .valid_o (geo_valid),
    .rad_o   (geo_rad),
    .side_o  (geo_side)
  );

  // ---------------- pipelined square root of the scaled distance
  logic                          sqrt_valid;
  logic [rfps_pkg::RootBits-1:0] sqrt_root;
  rfps_pkg::side_t               sqrt_side;

  rfps_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (geo_valid),
    .rad_i   (geo_rad),
    .side_i  (geo_side),
    .valid_o (sqrt_valid),
    .root_o  (sqrt_root),
    .side_o  (sqrt_side)
  );

  // ---------------- coverage and channel scaling, holds the output register
  rfps_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (sqrt_valid),
    .root_i  (sqrt_root),
    .side_i  (sqrt_side),
    .valid_o (out_valid_o),
    .argb_o  (pixel_argb_o)
  );

endmodule

FILE: test/frame_shade_checker.sv
`timescale 1ns / 1ps

package rfps_tb_pkg;

  typedef enum logic [3:0] {
    REG_FRAME_WIDTH  = 4'd0,
    REG_FRAME_HEIGHT = 4'd1,
    REG_CORNER_RADIUS = 4'd2,
    REG_BORDER_WIDTH = 4'd3,
    REG_TITLE_HEIGHT = 4'd4,
    REG_BORDER_COLOR = 4'd5,
    REG_TITLE_COLOR  = 4'd6,
    REG_BODY_COLOR   = 4'd7
  } frame_reg_e;

  // first index past the register file
  localparam int unsigned RegCount = 8;

endpackage

module frame_shade_checker
  import rfps_pkg::*;
  import rfps_tb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [CoordBits-1:0] pixel_x_i,
  input  logic [CoordBits-1:0] pixel_y_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [ColorBits-1:0] pixel_argb_i,
  input  logic                 cfg_we_i,
  input  logic [3:0]           cfg_index_i,
  input  logic [ColorBits-1:0] cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [ColorBits-1:0] argb;
  } shade_expect_t;

  cfg_t          frame_cfg;
  shade_expect_t shade_q[$];
  int            fail_count;

  function automatic longint corner_span(input longint p, input longint size, input longint r);
    if (p < r) return r - 1 - p;
    if (p >= size - r) return p - size + r;
    return 0;
  endfunction

  function automatic longint floor_sqrt(input longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root + (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [ChanBits-1:0] fade_channel(input logic [ChanBits-1:0] c,
                                                       input logic [CovW-1:0] cov);
    int prod;
    prod = (int'(c) * int'(cov) + (1 << (CovBits - 1))) >>> CovBits;
    return ChanBits'(prod);
  endfunction

  function automatic logic [ColorBits-1:0] shade_pixel(input logic [CoordBits-1:0] px,
                                                       input logic [CoordBits-1:0] py,
                                                       input cfg_t c);
    longint x, y, w, h, r, bw, dx, dy, dist_sq;
    logic [CovW-1:0]      cov;
    logic [ColorBits-1:0] color;
    logic [ColorBits-1:0] argb;
    x  = longint'(px);
    y  = longint'(py);
    w  = longint'(c.frame_width);
    h  = longint'(c.frame_height);
    r  = longint'(c.corner_radius);
    bw = longint'(c.border_width);
    cov = CovW'(1 << CovBits);
    dx = corner_span(x, w, r);
    dy = corner_span(y, h, r);
    if (dx > 0 && dy > 0) begin
      dist_sq = dx * dx + dy * dy;
      if (dist_sq > r * r) begin
        cov = '0;
      end else if (dist_sq > (r - 1) * (r - 1)) begin
        // rounded root of the distance in coverage units, taken from the radius
        cov = CovW'((r << CovBits) - ((floor_sqrt(dist_sq << (2 * CovBits + 2)) + 1) >>> 1));
      end
    end
    if (x < bw || x >= w - bw || y >= h - bw) color = c.border_color;
    else if (y < longint'(c.title_height)) color = c.title_color;
    else color = c.body_color;
    for (int k = 0; k < 4; k++) argb[8*k +: 8] = fade_channel(color[8*k +: 8], cov);
    return argb;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    shade_expect_t head;
    shade_expect_t fresh;
    if (!rst_ni) begin
      frame_cfg = '{FrameWidthRst, FrameHeightRst, RadiusRst, BorderRst, TitleRst,
                    BorderColorRst, TitleColorRst, BodyColorRst};
      shade_q.delete();
      fail_count = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH:   frame_cfg.frame_width   = cfg_data_i[DimBits-1:0];
          REG_FRAME_HEIGHT:  frame_cfg.frame_height  = cfg_data_i[DimBits-1:0];
          REG_CORNER_RADIUS: frame_cfg.corner_radius = cfg_data_i[RadiusBits-1:0];
          REG_BORDER_WIDTH:  frame_cfg.border_width  = cfg_data_i[BandBits-1:0];
          REG_TITLE_HEIGHT:  frame_cfg.title_height  = cfg_data_i[TitleBits-1:0];
          REG_BORDER_COLOR:  frame_cfg.border_color  = cfg_data_i;
          REG_TITLE_COLOR:   frame_cfg.title_color   = cfg_data_i;
          REG_BODY_COLOR:    frame_cfg.body_color    = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        fresh.x = pixel_x_i;
        fresh.y = pixel_y_i;
        fresh.argb = shade_pixel(pixel_x_i, pixel_y_i, frame_cfg);
        shade_q.push_back(fresh);
      end
      if (out_valid_i && !out_stall_i) begin
        if (shade_q.size() == 0) begin
          fail_count++;
          $display("%0t pixel_argb transfer %08h with no pixel outstanding, expected none",
                   $time, pixel_argb_i);
        end else begin
          head = shade_q.pop_front();
          if (head.argb !== pixel_argb_i) begin
            fail_count++;
            $display("%0t pixel_argb mismatch for pixel (%0d,%0d): expected %08h, actual %08h",
                     $time, head.x, head.y, head.argb, pixel_argb_i);
          end
        end
      end
      fail_count_o <= fail_count;
      pending_o <= shade_q.size();
    end
  end

endmodule

FILE: test/rounded_frame_pixel_shader_tb.sv
`timescale 1ns / 1ps

module rounded_frame_pixel_shader_tb;
  import rfps_pkg::*;
  import rfps_tb_pkg::*;

  // random pixels per register setting, and number of settings
  localparam int PhaseItems    = 160;
  localparam int RandPhases    = 12;
  // long receiver hold-off, well past the pipe depth
  localparam int HoldOffCycles = 80;
  // quiet cycles after the last pixel, above the pipe depth
  localparam int SettleCycles  = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [CoordBits-1:0] pixel_x;
  logic [CoordBits-1:0] pixel_y;
  logic                 out_valid;
  logic                 out_stall;
  logic [ColorBits-1:0] pixel_argb;
  logic                 cfg_we;
  logic [3:0]           cfg_index;
  logic [ColorBits-1:0] cfg_data;

  int   fail_count;
  int   pending;

  // settings in force, used to aim pixels at corners and bands
  cfg_t cur_frame;
  // no idling on either side while set
  bit   steady;
  // asks the receiver for its one long hold-off
  bit   hold_off_req;

  rounded_frame_pixel_shader DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pixel_x_i    (pixel_x),
    .pixel_y_i    (pixel_y),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pixel_argb_o (pixel_argb),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  frame_shade_checker shade_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .pixel_x_i    (pixel_x),
    .pixel_y_i    (pixel_y),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .pixel_argb_i (pixel_argb),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the pipe hangs
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  // one register write, we stays high so back-to-back writes need no gap
  task automatic write_reg(input frame_reg_e idx, input logic [ColorBits-1:0] value,
                           input int bits);
    logic [ColorBits-1:0] junk;
    // junk above the field width must be dropped by the block
    junk = $urandom;
    if (bits < ColorBits) junk = junk << bits;
    else junk = '0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value | junk;
    @(posedge clk);
  endtask

  task automatic load_frame_cfg(input cfg_t c);
    write_reg(REG_FRAME_WIDTH,   ColorBits'(c.frame_width),   DimBits);
    write_reg(REG_FRAME_HEIGHT,  ColorBits'(c.frame_height),  DimBits);
    write_reg(REG_CORNER_RADIUS, ColorBits'(c.corner_radius), RadiusBits);
    write_reg(REG_BORDER_WIDTH,  ColorBits'(c.border_width),  BandBits);
    write_reg(REG_TITLE_HEIGHT,  ColorBits'(c.title_height),  TitleBits);
    write_reg(REG_BORDER_COLOR,  c.border_color,              ColorBits);
    write_reg(REG_TITLE_COLOR,   c.title_color,               ColorBits);
    write_reg(REG_BODY_COLOR,    c.body_color,                ColorBits);
    // an index past the register file changes nothing
    cfg_we <= 1'b1;
    cfg_index <= 4'($urandom_range(15, RegCount));
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_frame = c;
  endtask

  // offer one pixel, with a random gap first, and hold it until the transfer
  task automatic push_pixel(input logic [CoordBits-1:0] x, input logic [CoordBits-1:0] y);
    while (!steady && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait until every pixel has come back
  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [DimBits-1:0] roll_dim();
    int k;
    k = $urandom_range(99);
    // mostly small frames so that corners and bands get hit often
    if (k < 70) return DimBits'($urandom_range(300, 1));
    if (k < 90) return DimBits'($urandom_range(4096, 1));
    return DimBits'($urandom_range(8191, 0));
  endfunction

  function automatic cfg_t roll_frame();
    cfg_t c;
    int   lim;
    c.frame_width  = roll_dim();
    c.frame_height = roll_dim();
    // radius usually fits the frame, sometimes it does not
    lim = ((c.frame_width < c.frame_height) ? c.frame_width : c.frame_height) / 2;
    if (lim > 255) lim = 255;
    if ($urandom_range(99) < 70) c.corner_radius = RadiusBits'($urandom_range(lim, 0));
    else c.corner_radius = RadiusBits'($urandom_range(255, 0));
    if ($urandom_range(99) < 70) c.border_width = BandBits'($urandom_range(8, 0));
    else c.border_width = BandBits'($urandom_range(255, 0));
    if ($urandom_range(99) < 70) c.title_height = TitleBits'($urandom_range(40, 0));
    else c.title_height = TitleBits'($urandom_range(1023, 0));
    c.border_color = $urandom;
    c.title_color  = $urandom;
    c.body_color   = $urandom;
    return c;
  endfunction

  // pick a pixel: corner rims, edge strips, inside the frame, or anywhere
  task automatic aim_pixel(input cfg_t c, output logic [CoordBits-1:0] x,
                           output logic [CoordBits-1:0] y);
    int w, h, r, k, dx, dy, off;
    w = c.frame_width;
    h = c.frame_height;
    r = c.corner_radius;
    k = $urandom_range(99);
    if (k < 30 && r > 0) begin
      // on the antialiased rim of a random corner, or one step outside it
      dx = $urandom_range(r, 1);
      dy = 0;
      while ((dy + 1) * (dy + 1) + dx * dx <= r * r) dy++;
      dy += $urandom_range(1, 0);
      if (dy == 0) dy = 1;
      x = CoordBits'($urandom_range(1, 0) ? r - 1 - dx : w - r + dx);
      y = CoordBits'($urandom_range(1, 0) ? r - 1 - dy : h - r + dy);
    end else if (k < 55) begin
      // near the frame edges, crossing the border bands
      off = $urandom_range(r + 2, 0);
      x = CoordBits'($urandom_range(1, 0) ? off : w - 1 - off);
      off = $urandom_range(r + 2, 0);
      y = CoordBits'($urandom_range(1, 0) ? off : h - 1 - off);
    end else if (k < 85) begin
      x = CoordBits'($urandom_range((w > 0) ? w - 1 : 0, 0));
      y = CoordBits'($urandom_range((h > 0) ? h - 1 : 0, 0));
    end else begin
      // any coordinate, also outside the frame
      x = CoordBits'($urandom);
      y = CoordBits'($urandom);
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin : pixel_sink
    int held;
    held = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && held < HoldOffCycles) begin
        out_stall <= 1'b1;
        held++;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 15);
      end
    end
  end

  initial begin : pixel_source
    cfg_t                 fc;
    logic [CoordBits-1:0] px;
    logic [CoordBits-1:0] py;
    steady = 1'b0;
    hold_off_req = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    pixel_x <= '0;
    pixel_y <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= '0;
    cur_frame = '{FrameWidthRst, FrameHeightRst, RadiusRst, BorderRst, TitleRst,
                  BorderColorRst, TitleColorRst, BodyColorRst};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: square corners, 640x480 frame
    push_pixel(0, 0);
    push_pixel(12'hFFF, 12'hFFF);
    push_pixel(320, 10);
    push_pixel(320, 240);
    push_pixel(639, 479);
    push_pixel(700, 100);
    drain_pixels();

    // small frame with radius 10: outside corner, rim, inside, bands
    load_frame_cfg('{frame_width: 64, frame_height: 48, corner_radius: 10,
                     border_width: 3, title_height: 8, border_color: 32'h8040_2010,
                     title_color: 32'hFF12_3456, body_color: 32'hC0FF_007F});
    push_pixel(0, 0);    // past the curve, no coverage
    push_pixel(1, 3);    // right on the radius, partial that rounds to zero
    push_pixel(2, 3);    // inside the antialiasing ring
    push_pixel(5, 5);    // well inside the curve
    push_pixel(63, 47);  // far corner, no coverage
    push_pixel(60, 2);   // top right ring
    push_pixel(30, 5);   // title band
    push_pixel(30, 30);  // body
    push_pixel(30, 46);  // bottom band
    push_pixel(1, 30);   // left band
    drain_pixels();

    // frame covering every coordinate, largest radius, bands and title, extreme colors
    load_frame_cfg('{frame_width: 4096, frame_height: 4096, corner_radius: 255,
                     border_width: 255, title_height: 1023, border_color: 32'h0000_0000,
                     title_color: 32'hFFFF_FFFF, body_color: 32'h7F80_01FE});
    push_pixel(0, 0);
    push_pixel(74, 74);  // ring of the widest curve
    push_pixel(12'hFFF, 0);
    push_pixel(0, 12'hFFF);
    push_pixel(2000, 2000);
    push_pixel(2000, 500);

    // random settings; the first two are all zeros and all ones
    for (int phase = 0; phase < RandPhases; phase++) begin
      drain_pixels();
      if (phase == 0) fc = '0;
      else if (phase == 1) fc = '1;
      else fc = roll_frame();
      load_frame_cfg(fc);
      steady = (phase == 4);
      // fills the pipe while the sender keeps offering
      if (phase == 6) hold_off_req = 1'b1;
      repeat (PhaseItems) begin
        aim_pixel(cur_frame, px, py);
        push_pixel(px, py);
      end
    end

    drain_pixels();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
